// ===== hw/rtl/sorted_table_bound_search_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table bound search
// Concurrent assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BOUND_SEARCH_TOP_DEFINES_SVH
`define SORTED_TABLE_BOUND_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define STBS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define STBS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define STBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STBS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`define STBS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define STBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table bound search package
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int STBS_TABLE_DEPTH = 256;
    localparam int STBS_VALUE_WIDTH = 32;

    localparam int COUNT_W = 9;    // entry_count and result indexes
    localparam int INDEX_W = 8;    // load index
    localparam int KEY_W   = 32;   // value field on the stream

    localparam int IN_TDATA_W  = ((INDEX_W + KEY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((1 + 2 * COUNT_W + 7) / 8) * 8;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // search lanes, visited round robin
    localparam logic [1:0] LANE_EXACT = 2'd0;
    localparam logic [1:0] LANE_LOWER = 2'd1;
    localparam logic [1:0] LANE_UPPER = 2'd2;

    typedef struct packed {
        logic load_we;   // write one table entry
        logic start;     // capture key, open all three search windows
        logic step;      // issue one probe slot
        logic publish;   // move the bounds into the output register
    } t_stbs_cmd;

    typedef struct packed {
        logic busy;      // a lane is still open or a probe is in flight
        logic out_free;  // output register can take a result this cycle
    } t_stbs_status;

endpackage

// ===== hw/rtl/sorted_table_bound_search_top.sv =====
// ----------------------------------------------------------------------------
// Sorted table bound search, top level
// Load: one transfer per cycle while no query is open, written to the table at the accept edge.
// Query: three searches share one table read port round robin, at most one probe
// per cycle, with P <= ceil(log2(n+1)) probes per search. The result is registered
// once every lane has closed, and the next transfer is taken after the result is
// published; a waiting result holds the input off.
// Reset clears entry_count, the controller and the output valid, not the table.
// ----------------------------------------------------------------------------
`include "sorted_table_bound_search_top_defines.svh"

module sorted_table_bound_search_top #(
    parameter int TABLE_DEPTH = stbs_pkg::STBS_TABLE_DEPTH,
    parameter int VALUE_WIDTH = stbs_pkg::STBS_VALUE_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: entry_count
    input  logic                              i_cfg_we,
    input  logic [stbs_pkg::COUNT_W-1:0]      i_cfg_wdata,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata, lowest bit up: entry_index[7:0], value[39:8]
    input  logic [stbs_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: cmd[0] (load or query)
    input  logic [0:0]                        i_s_axis_tuser,
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata, lowest bit up: found[0], lower_index[9:1], upper_index[18:10], zero pad
    output logic [stbs_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import stbs_pkg::*;

    t_stbs_cmd          s_cmd;
    t_stbs_status       s_status;
    logic [INDEX_W-1:0] s_entry_index;
    logic [KEY_W-1:0]   s_value;
    logic               s_found;
    logic [COUNT_W-1:0] s_lower;
    logic [COUNT_W-1:0] s_upper;

    // unpack the input transfer
    assign s_entry_index = i_s_axis_tdata[INDEX_W-1:0];
    assign s_value       = i_s_axis_tdata[INDEX_W+KEY_W-1:INDEX_W];

    stbs_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_query         (i_s_axis_tuser[0]),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (s_status),
        .o_cmd           (s_cmd)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_entry_index   (s_entry_index),
        .i_value         (s_value),
        .i_cmd           (s_cmd),
        .o_status        (s_status),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_found         (s_found),
        .o_lower_index   (s_lower),
        .o_upper_index   (s_upper)
    );

    // pack the result transfer, zero fill to whole bytes
    assign o_m_axis_tdata = {{(OUT_TDATA_W - 1 - 2*COUNT_W){1'b0}}, s_upper, s_lower, s_found};

    // the input side only opens once every lane has closed
    `STBS_ASSERT_IMPLIES(a_ready_not_busy, i_clk, i_rst_n,
        o_s_axis_tready && !s_cmd.publish, !s_status.busy,
        "input ready while a search is in progress")
    // a result never overwrites one that is still waiting
    `STBS_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n,
        s_cmd.publish && o_m_axis_tvalid && !i_m_axis_tready,
        "result published over a stalled result")
    // an accepted query closes the input side on the next cycle
    `STBS_ASSERT_NEXT(a_query_blocks, i_clk, i_rst_n,
        s_cmd.start, !o_s_axis_tready,
        "input still ready after a query transfer")

endmodule

// ===== hw/rtl/stbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted table bound search controller
// Accepts stream items and sequences query searches and result hand-off.
// ----------------------------------------------------------------------------
module stbs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    input  logic                  i_query,
    output logic                  o_s_axis_tready,
    input  stbs_pkg::t_stbs_status i_status,
    output stbs_pkg::t_stbs_cmd   o_cmd
);
    import stbs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   finish;

    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        accept          = o_s_axis_tready && i_s_axis_tvalid;
        finish          = (r_state != S_IDLE) && !i_status.busy;

        o_cmd.load_we = accept && (i_query == CMD_LOAD);
        o_cmd.start   = accept && (i_query == CMD_QUERY);
        o_cmd.step    = (r_state == S_SEARCH);
        o_cmd.publish = finish && i_status.out_free;

        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.start) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (finish) begin
                    n_state = i_status.out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/stbs_datapath.sv =====
// ----------------------------------------------------------------------------
// Sorted table bound search datapath
// Table memory, three interleaved probe lanes and the output register.
// ----------------------------------------------------------------------------
module stbs_datapath #(
    parameter int TABLE_DEPTH = stbs_pkg::STBS_TABLE_DEPTH,
    parameter int VALUE_WIDTH = stbs_pkg::STBS_VALUE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [stbs_pkg::COUNT_W-1:0]   i_cfg_wdata,
    input  logic [stbs_pkg::INDEX_W-1:0]   i_entry_index,
    input  logic [stbs_pkg::KEY_W-1:0]     i_value,
    input  stbs_pkg::t_stbs_cmd            i_cmd,
    output stbs_pkg::t_stbs_status         o_status,
    input  logic                           i_m_axis_tready,
    output logic                           o_m_axis_tvalid,
    output logic                           o_found,
    output logic [stbs_pkg::COUNT_W-1:0]   o_lower_index,
    output logic [stbs_pkg::COUNT_W-1:0]   o_upper_index
);
    import stbs_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

    logic [COUNT_W-1:0]     r_entry_count;
    logic [COUNT_W-1:0]     n_active;
    logic [VALUE_WIDTH-1:0] r_key;
    logic [VALUE_WIDTH-1:0] r_rd_data;

    logic [COUNT_W-1:0] r_b_ex, r_e_ex, r_b_lo, r_e_lo, r_b_up, r_e_up;
    logic               r_found;
    logic [1:0]         r_lane;
    logic               r_rd_vld;
    logic [1:0]         r_rd_lane;
    logic [COUNT_W-1:0] r_rd_m;
    logic               r_out_valid;

    logic               act_ex, act_lo, act_up;
    logic [COUNT_W-1:0] iss_b, iss_e, span, mid;
    logic               iss_act, iss_bias, issue;
    logic               load_ok;
    logic               key_lt, key_eq;

    // saturate the count at the table depth
    always_comb begin
        if (32'(r_entry_count) > 32'(TABLE_DEPTH)) begin
            n_active = COUNT_W'(TABLE_DEPTH);
        end else begin
            n_active = r_entry_count;
        end
        load_ok = (32'(i_entry_index) < 32'(TABLE_DEPTH));
    end

    // all lanes keep an exclusive end; the exact lane's midpoint rounds one lower
    always_comb begin
        act_ex = (r_b_ex < r_e_ex) && !r_found;
        act_lo = (r_b_lo < r_e_lo);
        act_up = (r_b_up < r_e_up);
        case (r_lane)
            LANE_EXACT: begin
                iss_b = r_b_ex; iss_e = r_e_ex; iss_act = act_ex; iss_bias = 1'b1;
            end
            LANE_LOWER: begin
                iss_b = r_b_lo; iss_e = r_e_lo; iss_act = act_lo; iss_bias = 1'b0;
            end
            LANE_UPPER: begin
                iss_b = r_b_up; iss_e = r_e_up; iss_act = act_up; iss_bias = 1'b0;
            end
            default: begin
                iss_b = r_b_up; iss_e = r_e_up; iss_act = 1'b0; iss_bias = 1'b0;
            end
        endcase
        span  = iss_e - iss_b;
        mid   = iss_b + ((span - {{(COUNT_W-1){1'b0}}, iss_bias}) >> 1);
        issue = i_cmd.step && iss_act;

        key_lt = $signed(r_rd_data) < $signed(r_key);
        key_eq = (r_rd_data == r_key);

        o_status.busy     = r_rd_vld || act_ex || act_lo || act_up;
        o_status.out_free = !r_out_valid || i_m_axis_tready;
    end

    // table memory: one write port for loads, one registered read for probes
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && load_ok) begin
            mem[ADDR_W'(i_entry_index)] <= VALUE_WIDTH'(i_value);
        end
        if (issue) begin
            r_rd_data <= mem[ADDR_W'(mid)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_b_ex        <= '0;
            r_e_ex        <= '0;
            r_b_lo        <= '0;
            r_e_lo        <= '0;
            r_b_up        <= '0;
            r_e_up        <= '0;
            r_found       <= 1'b0;
            r_lane        <= LANE_EXACT;
            r_rd_vld      <= 1'b0;
            r_rd_lane     <= LANE_EXACT;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_wdata;
            end
            if (i_cmd.start) begin
                r_b_ex   <= '0;
                r_e_ex   <= n_active;
                r_b_lo   <= '0;
                r_e_lo   <= n_active;
                r_b_up   <= '0;
                r_e_up   <= n_active;
                r_found  <= 1'b0;
                r_lane   <= LANE_EXACT;
                r_rd_vld <= 1'b0;
            end else begin
                r_rd_vld  <= issue;
                r_rd_lane <= r_lane;
                if (i_cmd.step) begin
                    r_lane <= (r_lane == LANE_UPPER) ? LANE_EXACT : r_lane + 2'd1;
                end
                if (r_rd_vld) begin
                    case (r_rd_lane)
                        LANE_EXACT: begin
                            if (key_lt) begin
                                r_b_ex <= r_rd_m + 1'b1;
                            end else if (!key_eq) begin
                                r_e_ex <= r_rd_m;
                            end else begin
                                r_found <= 1'b1;
                            end
                        end
                        LANE_LOWER: begin
                            if (key_lt) begin
                                r_b_lo <= r_rd_m + 1'b1;
                            end else begin
                                r_e_lo <= r_rd_m;
                            end
                        end
                        LANE_UPPER: begin
                            if (key_lt || key_eq) begin
                                r_b_up <= r_rd_m + 1'b1;
                            end else begin
                                r_e_up <= r_rd_m;
                            end
                        end
                        default: begin
                            r_found <= r_found;
                        end
                    endcase
                end
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key <= VALUE_WIDTH'(i_value);
        end
        if (issue) begin
            r_rd_m <= mid;
        end
        if (i_cmd.publish) begin
            o_found       <= r_found;
            o_lower_index <= r_b_lo;
            o_upper_index <= r_b_up;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted table bound search testbench
// Loads table entries and issues key queries over the stream ports, predicts
// the found flag and both bound indexes with an independent binary search
// model, and compares every result transfer field by field, in order.
// ----------------------------------------------------------------------------

module tb;
    import stbs_pkg::*;

    localparam int ITEM_TARGET  = 1200;    // stop issuing stimulus past this count
    localparam int QUIET_AFTER  = 1060;    // no gaps or stalls from here on
    localparam int DRAIN_CYCLES = 40;      // longer than one full query latency
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
    localparam int CYCLE_LIMIT  = 500000;  // watchdog

    localparam int KEY_MIN = 32'sh8000_0000;
    localparam int KEY_MAX = 32'sh7fff_ffff;

    // how a run of loads fills the table
    typedef enum int {
        FILL_SPREAD,     // ascending, wide steps, may start at the minimum
        FILL_DUPS,       // ascending, steps of 0..2, many duplicates
        FILL_SATURATE,   // ascending into the maximum, long duplicate tail
        FILL_RANDOM      // unsorted
    } t_fill_style;

    // one predicted result, same field order as the result tdata
    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] lower;
        logic [COUNT_W-1:0] upper;
    } t_bounds;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the table and the entry count, predicts each query
    // result at its input transfer and checks result transfers in order.
    // ------------------------------------------------------------------------
    class bound_search_scoreboard;
        int      entries[STBS_TABLE_DEPTH];
        int      entry_count = 0;
        int      errors = 0;
        t_bounds pending_bounds[$];

        task report(string msg);
            $display("%0t ns: %s", $time, msg);
            errors++;
        endtask

        // entry_count saturates at the table depth
        function int active_entries();
            return (entry_count > STBS_TABLE_DEPTH) ? STBS_TABLE_DEPTH : entry_count;
        endfunction

        function bit exact_hit(int n, int key);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = n - 1;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (entries[mid] < key) begin
                    lo = mid + 1;
                end else if (entries[mid] > key) begin
                    hi = mid - 1;
                end else begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // strict = 0: first entry not less than key; strict = 1: first entry above key
        function int bound_index(int n, int key, bit strict);
            int lo;
            int hi;
            int mid;
            bit go_right;
            lo = 0;
            hi = n;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                go_right = strict ? (entries[mid] <= key) : (entries[mid] < key);
                if (go_right) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            return lo;
        endfunction

        function void note_transfer(logic cmd, logic [INDEX_W-1:0] index, int value);
            t_bounds b;
            int n;
            if (cmd == CMD_LOAD) begin
                entries[index] = value;
            end else begin
                n       = active_entries();
                b.found = exact_hit(n, value);
                b.lower = COUNT_W'(bound_index(n, value, 1'b0));
                b.upper = COUNT_W'(bound_index(n, value, 1'b1));
                pending_bounds.push_back(b);
            end
        endfunction

        task check_result(logic [OUT_TDATA_W-1:0] tdata);
            t_bounds want;
            logic found;
            logic [COUNT_W-1:0] lower;
            logic [COUNT_W-1:0] upper;
            found = tdata[0];
            lower = tdata[COUNT_W:1];
            upper = tdata[2*COUNT_W:COUNT_W+1];
            if (pending_bounds.size() == 0) begin
                report($sformatf("result with no query outstanding, tdata=%h", tdata));
                return;
            end
            want = pending_bounds.pop_front();
            if (found !== want.found)
                report($sformatf("found: got %b, want %b", found, want.found));
            if (lower !== want.lower)
                report($sformatf("lower_index: got %0d, want %0d", lower, want.lower));
            if (upper !== want.upper)
                report($sformatf("upper_index: got %0d, want %0d", upper, want.upper));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                   i_clk;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_we        = 1'b0;
    logic [COUNT_W-1:0]     i_cfg_wdata     = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // tdata, lowest bit up: entry_index[7:0], value[39:8]
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    // tuser: cmd[0]
    logic [0:0]             i_s_axis_tuser  = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // tdata, lowest bit up: found[0], lower_index[9:1], upper_index[18:10], zero pad
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    bound_search_scoreboard sb;
    int   items_sent   = 0;
    bit   tx_gaps      = 1'b0;   // sender inserts idle bursts
    logic rx_stalls    = 1'b0;   // receiver inserts stall bursts
    bit   hold_request = 1'b0;   // ask for the long receiver hold-off
    logic hold_active  = 1'b0;
    int   stall_left   = 0;

    sorted_table_bound_search_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Sender tasks. Every task returns in the time step of a rising edge, so
    // the next drive lands before the following edge.
    // ------------------------------------------------------------------------

    // Offer one item, hold it until the transfer, then hand it to the scoreboard.
    // Leave tvalid high: the next call either replaces the data or drops valid.
    // No idling once the quiet tail of the run has begun.
    task automatic send_item(logic cmd, logic [INDEX_W-1:0] index, int value);
        int gap;
        gap = (tx_gaps && items_sent < QUIET_AFTER && $urandom_range(0, 3) == 0) ?
              $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_TDATA_W'({value, index});
        i_s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        sb.note_transfer(cmd, index, value);
        items_sent++;
    endtask

    // The entry_index field of a query is ignored: fill it with noise.
    task automatic send_query(int key);
        send_item(CMD_QUERY, INDEX_W'($urandom), key);
    endtask

    // Drain all outstanding results, let the block settle, then write the count.
    // Loads leave nothing in the scoreboard, so the extra cycles cover them.
    task automatic write_entry_count(int count);
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_bounds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= COUNT_W'(count);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.entry_count = count;
    endtask

    // Load entries 0..n-1 in index order.
    task automatic load_run(int n, t_fill_style style);
        longint level;
        int     step_max;
        int     value;
        case (style)
            FILL_SPREAD: begin
                level    = ($urandom_range(0, 3) == 0) ? KEY_MIN : longint'(int'($urandom)) / 4;
                step_max = 1 << 23;
            end
            FILL_DUPS: begin
                level    = longint'(int'($urandom)) / 2;
                step_max = 2;
            end
            FILL_SATURATE: begin
                level    = KEY_MAX - $urandom_range(0, 64);
                step_max = 8;
            end
            default: begin
                level    = 0;
                step_max = 0;
            end
        endcase
        for (int i = 0; i < n; i++) begin
            if (style == FILL_RANDOM) begin
                value = int'($urandom);
            end else begin
                level = level + $urandom_range(0, step_max);
                if (level > KEY_MAX) level = KEY_MAX;
                value = int'(level);
            end
            send_item(CMD_LOAD, INDEX_W'(i), value);
        end
    endtask

    // Keys: mostly hits on live entries or their neighbors, some extremes and noise.
    function automatic int pick_key(int n);
        int r;
        r = $urandom_range(0, 9);
        if (n > 0 && r < 4) return sb.entries[$urandom_range(0, n - 1)];
        if (n > 0 && r < 6) return sb.entries[$urandom_range(0, n - 1)] +
                                   (($urandom_range(0, 1) == 1) ? 1 : -1);
        if (r == 6) return ($urandom_range(0, 1) == 1) ? KEY_MAX : KEY_MIN;
        if (r == 7) return int'($urandom_range(0, 8)) - 4;
        return int'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: check every result transfer, then choose tready for the next
    // edge. Stall in bursts when enabled and before the quiet tail; hold off
    // entirely while the long hold-off runs.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata);
        if (hold_active) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (rx_stalls && items_sent < QUIET_AFTER && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Long hold-off, counted here: the sender keeps offering queries meanwhile,
    // so the result register fills and the block drops tready on its input.
    initial begin
        wait (hold_request);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    // Watchdog: a missing result or a stuck handshake ends here.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, sb.pending_bounds.size());
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int count;
        int n;
        int nq;
        bit quiet;
        t_fill_style style;

        sb = new;
        // Hold reset, then release it at an edge.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---
        // Empty table after reset: every search ends at once with index 0.
        send_query(KEY_MIN);
        send_query(KEY_MAX);
        // Extremes, a duplicate pair, and the top index.
        send_item(CMD_LOAD, 8'd0,   KEY_MIN);
        send_item(CMD_LOAD, 8'd1,   -5);
        send_item(CMD_LOAD, 8'd2,   7);
        send_item(CMD_LOAD, 8'd3,   7);
        send_item(CMD_LOAD, 8'd4,   KEY_MAX);
        send_item(CMD_LOAD, 8'd255, 0);
        write_entry_count(5);
        send_query(KEY_MIN);    // hit at the first entry
        send_query(KEY_MAX);    // hit at the last entry
        send_query(7);          // duplicate: bounds straddle the pair
        send_query(6);          // miss between entries
        send_query(-6);
        send_query(0);
        send_query(8);
        // One live entry.
        write_entry_count(1);
        send_query(-1);
        send_query(KEY_MIN);
        // Break the ordering: searches still follow their probe paths.
        send_item(CMD_LOAD, 8'd1, KEY_MAX);
        send_item(CMD_LOAD, 8'd3, KEY_MIN);
        write_entry_count(5);
        send_query(7);
        send_query(0);
        send_query(-5);

        // --- random phases ---
        // Phase 0 fills the whole table, so any later count reads written
        // entries only; phase 1 then uses the largest count, which saturates.
        for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
            if (phase == 0) begin
                count = STBS_TABLE_DEPTH;
            end else if (phase == 1) begin
                count = (1 << COUNT_W) - 1;
            end else begin
                case ($urandom_range(0, 19))
                    0:       count = 0;
                    1:       count = 1;
                    2:       count = 2;
                    3:       count = STBS_TABLE_DEPTH;
                    4:       count = $urandom_range(STBS_TABLE_DEPTH + 1, (1 << COUNT_W) - 1);
                    default: count = $urandom_range(3, 40);
                endcase
            end
            n = (count > STBS_TABLE_DEPTH) ? STBS_TABLE_DEPTH : count;
            write_entry_count(count);

            // Vary idling per phase, including phases with none; none at the end.
            quiet   = (items_sent >= QUIET_AFTER);
            tx_gaps = !quiet && ($urandom_range(0, 2) != 0);
            rx_stalls <= !quiet && ($urandom_range(0, 2) != 0);

            // Refill most phases; otherwise reuse what is already loaded.
            // Skip a refill that would run far past the item target.
            if (phase == 0 || (phase > 1 && $urandom_range(0, 3) != 0 &&
                               items_sent + n <= ITEM_TARGET)) begin
                style = ($urandom_range(0, 4) == 0) ? FILL_RANDOM
                                                    : t_fill_style'($urandom_range(0, 2));
                load_run(n, style);
            end

            nq = (phase == 2) ? 40 : $urandom_range(4, 30);
            if (phase == 2) hold_request = 1'b1;
            for (int q = 0; q < nq; q++) begin
                // Stray loads overwrite entries mid-phase and may unsort the table.
                if ($urandom_range(0, 14) == 0)
                    send_item(CMD_LOAD, INDEX_W'($urandom), int'($urandom));
                else
                    send_query(pick_key(n));
            end
        end

        // --- wind down ---
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_bounds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
